### rtl/core/soa_pkg.sv
// Shared types and constants for the slab object allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package soa_pkg;

  localparam int NUM_ARENAS  = 4;
  localparam int MAX_SLOTS   = 256;
  localparam int ARENA_BYTES = 4096;

  localparam int ARENA_W     = $clog2(NUM_ARENAS);
  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int LEN_W       = $clog2(NUM_ARENAS + 1);
  localparam int LINK_AW     = ARENA_W + SLOT_W;
  localparam int LINK_DEPTH  = NUM_ARENAS * MAX_SLOTS;
  localparam int OBJ_W       = 10;
  localparam int ADDR_W      = 14;
  localparam int PROD_W      = SLOT_W + OBJ_W;
  localparam int ARENA_SHIFT = $clog2(ARENA_BYTES);
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [OBJ_W-1:0] OBJ_SIZE_RST = OBJ_W'(16);
  localparam logic [CNT_W-1:0] SLOTS_RST    = CNT_W'(251);

  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_ARENA = CFG_IDX_W'(1);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NOSPACE = 2'd1,
    STATUS_BAD     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } fsm_e;

  typedef logic [ARENA_W-1:0] arena_t;
  typedef logic [SLOT_W-1:0]  slot_t;

  // allocation target offered by the arena bookkeeping
  typedef struct packed {
    logic   found;
    arena_t arena;
  } pick_t;

  // state update issued by the controller
  typedef struct packed {
    logic   en;
    logic   is_alloc;
    arena_t arena;
    slot_t  head;
  } commit_t;

endpackage

`default_nettype wire

### rtl/core/soa_link_ram.sv
// Slot link memory: one next-slot link per slot of every arena.
// One write port, one read port with registered data. Uses soa_pkg.
`default_nettype none

module soa_link_ram
  import soa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [LINK_AW-1:0] waddr_i,
  input  wire slot_t              wdata_i,
  input  wire logic               re_i,
  input  wire logic [LINK_AW-1:0] raddr_i,
  output slot_t                   rdata_o
);

  slot_t mem [LINK_DEPTH];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/soa_arena_state.sv
// Per-arena bookkeeping: chain heads, free counts, ordered partial and
// empty lists. Uses soa_pkg.
`default_nettype none

module soa_arena_state
  import soa_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rebuild_i,
  input  wire logic [CNT_W-1:0] eff_slots_i,
  input  wire arena_t           q_arena_i,
  output slot_t                 q_head_o,
  output logic [CNT_W-1:0]      q_count_o,
  output pick_t                 pick_o,
  input  wire commit_t          commit_i
);

  typedef struct packed {
    arena_t [NUM_ARENAS-1:0] order;
    logic [LEN_W-1:0]        len;
  } list_t;

  function automatic list_t list_drop(list_t l, arena_t a);
    list_t r;
    logic hit;
    arena_t pos;
    r = l;
    hit = 1'b0;
    pos = '0;
    for (int i = 0; i < NUM_ARENAS; i++) begin
      if (!hit && (LEN_W'(i) < l.len) && (l.order[i] == a)) begin
        hit = 1'b1;
        pos = ARENA_W'(i);
      end
    end
    if (hit) begin
      for (int j = 0; j < NUM_ARENAS - 1; j++) begin
        if ((ARENA_W'(j) >= pos) && (LEN_W'(j + 1) < l.len)) begin
          r.order[j] = l.order[j+1];
        end
      end
      r.len = l.len - LEN_W'(1);
    end
    return r;
  endfunction

  function automatic list_t list_front(list_t l, arena_t a);
    list_t r;
    r = l;
    if (l.len < LEN_W'(NUM_ARENAS)) begin
      for (int j = 1; j < NUM_ARENAS; j++) begin
        if (LEN_W'(j) <= l.len) begin
          r.order[j] = l.order[j-1];
        end
      end
      r.order[0] = a;
      r.len = l.len + LEN_W'(1);
    end
    return r;
  endfunction

  function automatic list_t list_back(list_t l, arena_t a);
    list_t r;
    r = l;
    if (l.len < LEN_W'(NUM_ARENAS)) begin
      r.order[l.len[ARENA_W-1:0]] = a;
      r.len = l.len + LEN_W'(1);
    end
    return r;
  endfunction

  slot_t            head_q  [NUM_ARENAS];
  slot_t            head_d  [NUM_ARENAS];
  logic [CNT_W-1:0] count_q [NUM_ARENAS];
  logic [CNT_W-1:0] count_d [NUM_ARENAS];
  list_t            part_q, part_d;
  list_t            empt_q, empt_d;
  logic [CNT_W-1:0] cnt_new;

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    part_d  = part_q;
    empt_d  = empt_q;
    cnt_new = count_q[commit_i.arena];
    if (rebuild_i) begin
      for (int k = 0; k < NUM_ARENAS; k++) begin
        head_d[k]        = SLOT_W'(eff_slots_i - CNT_W'(1));
        count_d[k]       = eff_slots_i;
        part_d.order[k]  = '0;
        empt_d.order[k]  = ARENA_W'(k);
      end
      part_d.len = '0;
      empt_d.len = LEN_W'(NUM_ARENAS);
    end else if (commit_i.en) begin
      if (commit_i.is_alloc) begin
        cnt_new = count_q[commit_i.arena] - CNT_W'(1);
      end else begin
        cnt_new = count_q[commit_i.arena] + CNT_W'(1);
      end
      count_d[commit_i.arena] = cnt_new;
      head_d[commit_i.arena]  = commit_i.head;
      if (commit_i.is_alloc) begin
        if (cnt_new == '0) begin
          part_d = list_drop(part_q, commit_i.arena);
          empt_d = list_drop(empt_q, commit_i.arena);
        end else if (cnt_new == eff_slots_i - CNT_W'(1)) begin
          // first slot taken from a fully free arena: move to partial tail
          empt_d = list_drop(empt_q, commit_i.arena);
          part_d = list_back(list_drop(part_q, commit_i.arena), commit_i.arena);
        end
      end else begin
        if (cnt_new == CNT_W'(1)) begin
          empt_d = list_drop(empt_q, commit_i.arena);
          part_d = list_front(list_drop(part_q, commit_i.arena), commit_i.arena);
        end else if (cnt_new == eff_slots_i) begin
          part_d = list_drop(part_q, commit_i.arena);
          empt_d = list_front(list_drop(empt_q, commit_i.arena), commit_i.arena);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_ARENAS; k++) begin
        head_q[k]        <= SLOT_W'(SLOTS_RST - CNT_W'(1));
        count_q[k]       <= SLOTS_RST;
        part_q.order[k]  <= '0;
        empt_q.order[k]  <= ARENA_W'(k);
      end
      part_q.len <= '0;
      empt_q.len <= LEN_W'(NUM_ARENAS);
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      part_q  <= part_d;
      empt_q  <= empt_d;
    end
  end

  assign q_head_o     = head_q[q_arena_i];
  assign q_count_o    = count_q[q_arena_i];
  assign pick_o.found = (part_q.len != '0) || (empt_q.len != '0);
  assign pick_o.arena = (part_q.len != '0) ? part_q.order[0] : empt_q.order[0];

  // the two lists together hold no more entries than there are arenas
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, part_q.len} + {1'b0, empt_q.len}) <= (LEN_W + 1)'(NUM_ARENAS))
    else $error("arena lists hold more entries than arenas");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rebuild_i |-> !commit_i.en)
    else $error("state update during rebuild");

  for (genvar g = 0; g < NUM_ARENAS; g++) begin : g_cnt_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      !rebuild_i |-> (count_q[g] <= eff_slots_i))
      else $error("free count above slots per arena");
  end

endmodule

`default_nettype wire

### rtl/core/slab_object_allocator_unit.sv
// Slab object allocator top level: config registers, request control,
// link memory init pass and result register. Uses soa_pkg, soa_link_ram,
// soa_arena_state.
`default_nettype none

// Each transaction has two steps: the accept step reads the head slot's
// link from the link memory, and the execute step uses the registered
// link to update the arena state (or writes the link of a freed slot) and
// loads the result register. A new request is taken while a result still
// waits downstream; only the execute step waits on a stalled output. After
// reset and after every write to object_size or slots_per_arena the link
// memory is reinitialized one entry per cycle, all 1024 entries, during which
// requests are stalled; writes to other register indexes are ignored.
module slab_object_allocator_unit
  import soa_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  req_type_i,
  input  wire logic [1:0]            ret_arena_i,
  input  wire logic [7:0]            free_slot_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 status_o,
  output logic [1:0]                 given_arena_o,
  output logic [7:0]                 given_slot_o,
  output logic [13:0]                byte_address_o,
  output logic [8:0]                 slots_left_o
);

  typedef struct packed {
    logic   is_free;
    logic   found;
    arena_t arena;
    slot_t  slot;
  } req_t;

  fsm_e               state_q, state_d;
  logic [LINK_AW-1:0] clr_q, clr_d;
  logic [OBJ_W-1:0]   object_size_q;
  logic [CNT_W-1:0]   slots_q;
  logic [CNT_W-1:0]   eff_slots;
  req_t               req_q;
  logic               out_valid_q;
  status_e            out_status_q;
  arena_t             out_arena_q;
  slot_t              out_slot_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [CNT_W-1:0]   out_left_q;

  logic               cfg_hit, accept, load, clearing, idle, exec;
  arena_t             q_arena;
  slot_t              q_head;
  logic [CNT_W-1:0]   q_count;
  pick_t              pick;
  commit_t            commit;
  logic               alloc_ok, free_ok;
  logic               link_we, link_re;
  logic [LINK_AW-1:0] link_waddr, link_raddr;
  slot_t              link_wdata, link_rdata, clr_slot;
  logic [PROD_W-1:0]  prod;
  logic [ADDR_W-1:0]  alloc_addr;
  status_e            res_status;
  arena_t             res_arena;
  slot_t              res_slot;
  logic [ADDR_W-1:0]  res_addr;
  logic [CNT_W-1:0]   res_left;

  localparam logic [LINK_AW-1:0] CLR_LAST = '1;

  // configuration
  assign cfg_hit = cfg_we_i &&
                   ((cfg_index_i == CFG_OBJECT_SIZE) || (cfg_index_i == CFG_SLOTS_PER_ARENA));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      object_size_q <= OBJ_SIZE_RST;
      slots_q       <= SLOTS_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_OBJECT_SIZE) begin
        object_size_q <= cfg_wdata_i[OBJ_W-1:0];
      end else if (cfg_index_i == CFG_SLOTS_PER_ARENA) begin
        slots_q <= cfg_wdata_i[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (slots_q == '0) begin
      eff_slots = CNT_W'(1);
    end else if (slots_q > CNT_W'(MAX_SLOTS)) begin
      eff_slots = CNT_W'(MAX_SLOTS);
    end else begin
      eff_slots = slots_q;
    end
  end

  // control FSM
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
    if (cfg_hit) begin
      state_d = ST_CLEAR;
    end
  end

  always_comb begin
    clearing   = 1'b0;
    idle       = 1'b0;
    exec       = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE: begin
        idle       = 1'b1;
        in_stall_o = 1'b0;
      end
      ST_EXEC:  exec = 1'b1;
      default:  clearing = 1'b1;
    endcase
  end

  assign accept = idle && in_valid_i;
  assign load   = exec && !(out_valid_q && out_stall_i);

  always_comb begin
    clr_d = clr_q;
    if (cfg_hit) begin
      clr_d = '0;
    end else if (clearing) begin
      clr_d = clr_q + LINK_AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // request capture
  assign q_arena = idle ? ((req_type_i == REQ_FREE) ? ret_arena_i : pick.arena)
                        : req_q.arena;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.is_free <= (req_type_i == REQ_FREE);
      req_q.found   <= pick.found;
      if (req_type_i == REQ_FREE) begin
        req_q.arena <= ret_arena_i;
        req_q.slot  <= free_slot_i;
      end else begin
        req_q.arena <= pick.arena;
        req_q.slot  <= q_head;
      end
    end
  end

  soa_arena_state u_arena_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rebuild_i   (clearing),
    .eff_slots_i (eff_slots),
    .q_arena_i   (q_arena),
    .q_head_o    (q_head),
    .q_count_o   (q_count),
    .pick_o      (pick),
    .commit_i    (commit)
  );

  // link memory: init pass writes the descending chain, a free writes the
  // old head into the freed slot, an allocate reads the head's link
  assign alloc_ok = req_q.found && (q_count != '0);
  assign free_ok  = ({1'b0, req_q.slot} < eff_slots) && (q_count < eff_slots);

  assign clr_slot   = (clr_q[SLOT_W-1:0] == '0) ? '0 : clr_q[SLOT_W-1:0] - SLOT_W'(1);
  assign link_we    = clearing || (load && req_q.is_free && free_ok);
  assign link_waddr = clearing ? clr_q : {req_q.arena, req_q.slot};
  assign link_wdata = clearing ? clr_slot : q_head;
  assign link_re    = accept && (req_type_i == REQ_ALLOC);
  assign link_raddr = {pick.arena, q_head};

  soa_link_ram u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  assign commit.en       = load && (req_q.is_free ? free_ok : alloc_ok);
  assign commit.is_alloc = !req_q.is_free;
  assign commit.arena    = req_q.arena;
  assign commit.head     = req_q.is_free ? req_q.slot : link_rdata;

  // result
  assign prod       = PROD_W'(req_q.slot) * PROD_W'(object_size_q);
  assign alloc_addr = (ADDR_W'(req_q.arena) << ARENA_SHIFT) + prod[ADDR_W-1:0];

  always_comb begin
    res_status = STATUS_OK;
    res_arena  = req_q.arena;
    res_slot   = req_q.slot;
    res_addr   = '0;
    res_left   = '0;
    if (req_q.is_free) begin
      if (free_ok) begin
        res_left = q_count + CNT_W'(1);
      end else begin
        res_status = STATUS_BAD;
      end
    end else if (alloc_ok) begin
      res_addr = alloc_addr;
      res_left = q_count - CNT_W'(1);
    end else begin
      res_status = STATUS_NOSPACE;
      res_arena  = '0;
      res_slot   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q <= res_status;
      out_arena_q  <= res_arena;
      out_slot_q   <= res_slot;
      out_addr_q   <= res_addr;
      out_left_q   <= res_left;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign given_arena_o  = out_arena_q;
  assign given_slot_o   = out_slot_q;
  assign byte_address_o = out_addr_q;
  assign slots_left_o   = out_left_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(link_we && link_re))
    else $error("link memory read and write in the same cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("result loaded outside execute step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clearing && (clr_q != CLR_LAST) && !cfg_hit) |=> (state_q == ST_CLEAR))
    else $error("init pass left early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clearing || exec) |-> in_stall_o)
    else $error("request taken while busy");

endmodule

`default_nettype wire

### test/tb_top.sv
// Testbench for slab_object_allocator_unit: directed table plus random
// alloc/free traffic, each result checked against a local allocator model
// or a listed expectation. Depends on soa_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_top;
  import soa_pkg::*;

  localparam int QUIET_LIMIT = 10000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 100;
  localparam int N_PHASES    = 8;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  typedef struct packed {
    status_e           status;
    arena_t            arena;
    slot_t             slot;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  left;
  } slab_result_t;

  typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic                  req;
    arena_t                arena;
    slot_t                 slot;
    logic                  typed;
    slab_result_t          want;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall_o;
  logic                  req_type   = REQ_ALLOC;
  logic [1:0]            ret_arena  = '0;
  logic [7:0]            free_slot  = '0;
  logic                  out_valid_o;
  logic                  out_stall  = 1'b0;
  logic [1:0]            status_o;
  logic [1:0]            given_arena_o;
  logic [7:0]            given_slot_o;
  logic [13:0]           byte_address_o;
  logic [8:0]            slots_left_o;

  // allocator model state
  int         obj_bytes;
  int         slots_cfg;
  logic [7:0] slot_link [NUM_ARENAS*MAX_SLOTS];
  int         chain_top [NUM_ARENAS];
  int         free_slots [NUM_ARENAS];
  int         part_list [$];
  int         empty_arenas [$];

  slab_result_t pending_results [$];
  int           held_objects [$];
  stim_row_t    dir_rows [$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int quiet_cycles   = 0;
  int stall_left     = 0;
  bit idle_on        = 1'b1;

  int phase_obj [N_PHASES]   = '{1023, 0, 1, 512, 37, 300, 100, 700};
  int phase_spa [N_PHASES]   = '{256, 0, 3, 2, 5, 1023, 8, 17};
  int phase_items [N_PHASES] = '{260, 180, 220, 180, 250, 240, 250, 250};

  slab_object_allocator_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type),
    .ret_arena_i    (ret_arena),
    .free_slot_i    (free_slot),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .status_o       (status_o),
    .given_arena_o  (given_arena_o),
    .given_slot_o   (given_slot_o),
    .byte_address_o (byte_address_o),
    .slots_left_o   (slots_left_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int usable_slots();
    int s;
    s = slots_cfg;
    if (s == 0) s = 1;
    if (s > MAX_SLOTS) s = MAX_SLOTS;
    return s;
  endfunction

  // every chain runs from the top slot down to 0, all arenas fully free
  function automatic void rebuild_arenas();
    int s;
    s = usable_slots();
    for (int a = 0; a < NUM_ARENAS; a++) begin
      for (int k = 0; k < MAX_SLOTS; k++)
        slot_link[a*MAX_SLOTS + k] = (k >= 1 && k < s) ? 8'(k - 1) : 8'd0;
      chain_top[a]  = s - 1;
      free_slots[a] = s;
    end
    part_list.delete();
    empty_arenas.delete();
    for (int a = 0; a < NUM_ARENAS; a++) empty_arenas.push_back(a);
  endfunction

  function automatic void drop_arena(ref int order [$], input int a);
    foreach (order[i]) begin
      if (order[i] == a) begin
        order.delete(i);
        return;
      end
    end
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_OBJECT_SIZE) obj_bytes = int'(data[9:0]);
    else if (idx == CFG_SLOTS_PER_ARENA) slots_cfg = int'(data[8:0]);
    else return;
    rebuild_arenas();
  endfunction

  function automatic slab_result_t serve_request(logic req, arena_t fa, slot_t fs);
    slab_result_t r;
    int s;
    int a;
    int sl;
    r = '0;
    s = usable_slots();
    if (req == REQ_ALLOC) begin
      if (part_list.size() > 0) a = part_list[0];
      else if (empty_arenas.size() > 0) a = empty_arenas[0];
      else begin
        r.status = STATUS_NOSPACE;
        return r;
      end
      if (free_slots[a] == 0) begin
        r.status = STATUS_NOSPACE;
        return r;
      end
      sl = chain_top[a] % MAX_SLOTS;
      chain_top[a] = int'(slot_link[a*MAX_SLOTS + sl]);
      free_slots[a]--;
      if (free_slots[a] == 0) begin
        drop_arena(part_list, a);
        drop_arena(empty_arenas, a);
      end else if (free_slots[a] == s - 1) begin
        drop_arena(empty_arenas, a);
        drop_arena(part_list, a);
        if (part_list.size() < NUM_ARENAS) part_list.push_back(a);
      end
      r.status = STATUS_OK;
      r.arena  = arena_t'(a);
      r.slot   = slot_t'(sl);
      r.addr   = ADDR_W'(a*ARENA_BYTES + sl*obj_bytes);
      r.left   = CNT_W'(free_slots[a]);
      return r;
    end
    r.arena = fa;
    r.slot  = fs;
    if (int'(fa) >= NUM_ARENAS || int'(fs) >= s || free_slots[fa] >= s) begin
      r.status = STATUS_BAD;
      return r;
    end
    slot_link[int'(fa)*MAX_SLOTS + int'(fs)] = 8'(chain_top[fa]);
    chain_top[fa] = int'(fs);
    free_slots[fa]++;
    if (free_slots[fa] == 1) begin
      // count-of-one rule first: with one-slot arenas a freed arena is partial
      drop_arena(part_list, int'(fa));
      drop_arena(empty_arenas, int'(fa));
      if (part_list.size() < NUM_ARENAS) part_list.push_front(int'(fa));
    end else if (free_slots[fa] == s) begin
      drop_arena(part_list, int'(fa));
      drop_arena(empty_arenas, int'(fa));
      if (empty_arenas.size() < NUM_ARENAS) empty_arenas.push_front(int'(fa));
    end
    r.status = STATUS_OK;
    r.left   = CNT_W'(free_slots[fa]);
    return r;
  endfunction

  function automatic void add_req(logic req, arena_t fa, slot_t fs);
    stim_row_t row;
    row       = '{kind: ROW_REQUEST, default: '0};
    row.req   = req;
    row.arena = fa;
    row.slot  = fs;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_checked(logic req, arena_t fa, slot_t fs, status_e st,
                                      arena_t ga, slot_t gs, int addr, int left);
    stim_row_t row;
    row       = '{kind: ROW_REQUEST, default: '0};
    row.req   = req;
    row.arena = fa;
    row.slot  = fs;
    row.typed = 1'b1;
    row.want  = '{st, ga, gs, ADDR_W'(addr), CNT_W'(left)};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, int data);
    stim_row_t row;
    row      = '{kind: ROW_CONFIG, default: '0};
    row.idx  = idx;
    row.data = CFG_DATA_W'(data);
    dir_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < MAX_REPORTS)
      $display("result %0d: %s got %0d, expected %0d", results_seen, what, got, want);
    mismatch_count++;
  endtask

  // one transaction; the expectation is formed at the accepting edge
  task automatic issue_request(logic req, arena_t fa, slot_t fs,
                               logic typed, slab_result_t typed_res);
    slab_result_t want;
    in_valid   <= 1'b1;
    req_type   <= req;
    ret_arena  <= fa;
    free_slot  <= fs;
    do @(posedge clk_i); while (in_stall_o);
    want = serve_request(req, fa, fs);
    if (req == REQ_ALLOC && want.status == STATUS_OK)
      held_objects.push_back(int'(want.arena)*MAX_SLOTS + int'(want.slot));
    pending_results.push_back(typed ? typed_res : want);
  endtask

  task automatic maybe_pause();
    if (idle_on && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    apply_register(idx, data);
    if (idx == CFG_OBJECT_SIZE || idx == CFG_SLOTS_PER_ARENA) held_objects.delete();
    // the link memory clear pass holds off requests
    repeat (2) @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // receiver stalls in bursts at random
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 99) < 15) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : result_check
    slab_result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, slot", int'(given_slot_o), -1);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", int'(status_o), int'(want.status));
        if (given_arena_o !== want.arena)
          report_mismatch("given_arena", int'(given_arena_o), int'(want.arena));
        if (given_slot_o !== want.slot)
          report_mismatch("given_slot", int'(given_slot_o), int'(want.slot));
        if (byte_address_o !== want.addr)
          report_mismatch("byte_address", int'(byte_address_o), int'(want.addr));
        if (slots_left_o !== want.left)
          report_mismatch("slots_left", int'(slots_left_o), int'(want.left));
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int     alloc_pct;
    int     roll;
    int     pick;
    int     handle;
    logic   req;
    arena_t fa;
    slot_t  fs;

    obj_bytes = int'(OBJ_SIZE_RST);
    slots_cfg = int'(SLOTS_RST);
    rebuild_arenas();

    // default setup: 251 slots, 16 byte objects
    add_checked(REQ_ALLOC, 2'd0, 8'd0, STATUS_OK, 2'd0, 8'd250, 4000, 250);
    add_checked(REQ_ALLOC, 2'd0, 8'd0, STATUS_OK, 2'd0, 8'd249, 3984, 249);
    add_checked(REQ_FREE, 2'd0, 8'd250, STATUS_OK, 2'd0, 8'd250, 0, 250);
    add_checked(REQ_FREE, 2'd0, 8'd249, STATUS_OK, 2'd0, 8'd249, 0, 251);
    add_checked(REQ_FREE, 2'd0, 8'd249, STATUS_BAD, 2'd0, 8'd249, 0, 0);
    add_checked(REQ_FREE, 2'd1, 8'd251, STATUS_BAD, 2'd1, 8'd251, 0, 0);
    add_checked(REQ_FREE, 2'd3, 8'd255, STATUS_BAD, 2'd3, 8'd255, 0, 0);
    add_req(REQ_ALLOC, 2'd0, 8'd0);
    // slot 0 was never handed out: accepted silently, chain holds it twice
    add_req(REQ_FREE, 2'd0, 8'd0);
    add_req(REQ_ALLOC, 2'd0, 8'd0);
    add_req(REQ_ALLOC, 2'd0, 8'd0);
    add_checked(REQ_FREE, 2'd2, 8'd0, STATUS_BAD, 2'd2, 8'd0, 0, 0);
    add_req(REQ_ALLOC, 2'd3, 8'd255);
    // one-slot arenas, 512 byte objects
    add_cfg(CFG_OBJECT_SIZE, 512);
    add_cfg(CFG_SLOTS_PER_ARENA, 1);
    add_checked(REQ_ALLOC, 2'd0, 8'd0, STATUS_OK, 2'd0, 8'd0, 0, 0);
    add_checked(REQ_ALLOC, 2'd0, 8'd0, STATUS_OK, 2'd1, 8'd0, 4096, 0);
    add_checked(REQ_ALLOC, 2'd0, 8'd0, STATUS_OK, 2'd2, 8'd0, 8192, 0);
    add_checked(REQ_ALLOC, 2'd0, 8'd0, STATUS_OK, 2'd3, 8'd0, 12288, 0);
    add_checked(REQ_ALLOC, 2'd1, 8'd7, STATUS_NOSPACE, 2'd0, 8'd0, 0, 0);
    add_checked(REQ_FREE, 2'd2, 8'd0, STATUS_OK, 2'd2, 8'd0, 0, 1);
    add_checked(REQ_FREE, 2'd2, 8'd0, STATUS_BAD, 2'd2, 8'd0, 0, 0);
    add_checked(REQ_ALLOC, 2'd0, 8'd0, STATUS_OK, 2'd2, 8'd0, 8192, 0);
    add_checked(REQ_FREE, 2'd1, 8'd1, STATUS_BAD, 2'd1, 8'd1, 0, 0);
    add_checked(REQ_FREE, 2'd1, 8'd0, STATUS_OK, 2'd1, 8'd0, 0, 1);
    add_checked(REQ_ALLOC, 2'd0, 8'd0, STATUS_OK, 2'd1, 8'd0, 4096, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CONFIG) begin
        write_register(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        maybe_pause();
        issue_request(dir_rows[i].req, dir_rows[i].arena, dir_rows[i].slot,
                      dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      idle_on = (p != N_PHASES - 1);
      write_register(CFG_OBJECT_SIZE, CFG_DATA_W'(phase_obj[p]));
      write_register(CFG_SLOTS_PER_ARENA, CFG_DATA_W'(phase_spa[p]));
      for (int n = 0; n < phase_items[p]; n++) begin
        // mid-phase: let everything drain, poke an unmapped index, carry on
        if (n == phase_items[p] / 2)
          write_register(p[0] ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom));
        // swing between filling and emptying so arenas change lists often
        alloc_pct = ((n / 30) % 2 == 0) ? 75 : 25;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          req = REQ_FREE;
          fa  = arena_t'($urandom_range(0, NUM_ARENAS - 1));
          fs  = (roll < 4) ? slot_t'($urandom_range(0, 255))
                           : slot_t'($urandom_range(0, usable_slots() - 1));
        end else if (held_objects.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
          req = REQ_ALLOC;
          fa  = arena_t'($urandom);
          fs  = slot_t'($urandom);
        end else begin
          pick   = $urandom_range(0, held_objects.size() - 1);
          handle = held_objects[pick];
          held_objects.delete(pick);
          req = REQ_FREE;
          fa  = arena_t'(handle / MAX_SLOTS);
          fs  = slot_t'(handle % MAX_SLOTS);
        end
        maybe_pause();
        issue_request(req, fa, fs, 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/soa_pkg.sv
rtl/core/soa_link_ram.sv
rtl/core/soa_arena_state.sv
rtl/core/slab_object_allocator_unit.sv
test/tb_top.sv
